// ----- rtl/lpjt_pkg.sv -----
// ----------------------------------------------------------------------------
// lpjt_pkg: shared types and codes for the linear-probe join table
// Operation and status codes, and the word passed from front to back end.
// ----------------------------------------------------------------------------
package lpjt_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd1;
  localparam logic [2:0] ST_BUCKET_FULL = 3'd2;
  localparam logic [2:0] ST_MATCH       = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

  localparam logic [1:0] CFG_HASH_SIZE  = 2'd0;
  localparam logic [1:0] CFG_BUILD_KEY  = 2'd1;
  localparam logic [1:0] CFG_STORED_KEY = 2'd2;
  localparam logic [1:0] CFG_PROBE_KEY  = 2'd3;

  // classified request word: triple plus the key picked for it
  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] f0;
    logic [31:0] f1;
    logic [31:0] f2;
  } req_t;

  function automatic logic [31:0] pick(input logic [1:0] sel, input logic [31:0] a,
                                       input logic [31:0] b, input logic [31:0] c);
    case (sel)
      2'd0:    pick = a;
      2'd1:    pick = b;
      default: pick = c;
    endcase
  endfunction

endpackage

// ----- rtl/lpjt_front.sv -----
// ----------------------------------------------------------------------------
// lpjt_front: input stage and request queue
// Accepts words, picks the key field by operation and queues the request.
// ----------------------------------------------------------------------------
module lpjt_front import lpjt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [31:0] first_field,
  input  logic [31:0] second_field,
  input  logic [31:0] third_field,
  input  logic [1:0]  build_sel,
  input  logic [1:0]  probe_sel,
  output logic        req_valid,
  output req_t        req,
  input  logic        req_take
);

  req_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  req_t       in_req;

  // classify the incoming word
  always_comb begin
    in_req.op  = op;
    in_req.f0  = first_field;
    in_req.f1  = second_field;
    in_req.f2  = third_field;
    in_req.key = pick((op == OP_INSERT) ? build_sel : probe_sel,
                      first_field, second_field, third_field);
  end

  assign full      = (cnt == 2'd2);
  assign req_valid = (cnt != 2'd0);
  assign req       = q[rp];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !full) begin
        q[wp] <= in_req;
        wp    <= ~wp;
      end
      if (req_take && req_valid) rp <= ~rp;
      cnt <= cnt + {1'b0, push && !full} - {1'b0, req_take && req_valid};
    end
  end

endmodule

// ----- rtl/lpjt_back.sv -----
// ----------------------------------------------------------------------------
// lpjt_back: probe engine and bucket store
// Reduces the key modulo the table size, walks buckets and reads out matches.
// ----------------------------------------------------------------------------
module lpjt_back import lpjt_pkg::*; #(
  parameter int NUM_BUCKETS  = 256,
  parameter int BUCKET_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  req_t        req,
  output logic        req_take,
  input  logic [8:0]  hash_size,
  input  logic [1:0]  build_sel,
  input  logic [1:0]  stored_sel,
  output logic        res_valid,
  input  logic        res_take,
  output logic [2:0]  status,
  output logic [31:0] out_first,
  output logic [31:0] out_second,
  output logic [31:0] out_third,
  output logic        last
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int DW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FW = $clog2(BUCKET_DEPTH + 1);
  localparam int SW = $clog2(NUM_BUCKETS + 1);
  localparam int EW = BW + DW;
  localparam int CW = SW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_PROBE, S_WAITRD, S_CHECK, S_READ, S_RWAIT, S_EMIT, S_RES
  } state_t;

  state_t state;

  // bucket state: valid-bit per bucket, fill count and entry store
  // fill is only meaningful while the bucket's valid bit is set
  logic [NUM_BUCKETS-1:0] used;
  logic [FW-1:0]          fill [NUM_BUCKETS];
  logic [31:0]            ef [NUM_BUCKETS << DW];
  logic [31:0]            es [NUM_BUCKETS << DW];
  logic [31:0]            et [NUM_BUCKETS << DW];
  logic [31:0]            rd_f, rd_s, rd_t;
  logic [EW-1:0]          rd_addr;
  logic                   rd_en, wr_en;
  logic [EW-1:0]          wr_addr;

  req_t          cur;
  logic [SW-1:0] size;
  logic [31:0]   rem;
  logic [5:0]    mstep;
  logic [BW-1:0] idx;
  logic [SW-1:0] steps;
  logic [FW-1:0] n, k;
  logic          b_used;
  logic [FW-1:0] b_fill;
  logic [SW-1:0] eff;
  logic [CW+31:0] trial;
  logic [31:0]   cmp;

  // effective table size: zero acts as one, clipped to the bucket count
  always_comb begin
    if (hash_size == 9'd0) eff = SW'(1);
    else if ({23'd0, hash_size} > 32'(NUM_BUCKETS)) eff = SW'(NUM_BUCKETS);
    else eff = SW'(hash_size);
  end

  assign req_take = (state == S_IDLE) && !res_valid;
  assign trial    = {{CW{1'b0}}, rem} - ({{CW{1'b0}}, 32'(size)} << mstep);
  assign cmp      = pick(cur.op == OP_INSERT ? build_sel : stored_sel, rd_f, rd_s, rd_t);

  // entry memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ef[wr_addr] <= cur.f0;
      es[wr_addr] <= cur.f1;
      et[wr_addr] <= cur.f2;
    end
    if (rd_en) begin
      rd_f <= ef[rd_addr];
      rd_s <= es[rd_addr];
      rd_t <= et[rd_addr];
    end
  end

  always_comb begin
    rd_en   = (state == S_PROBE) || (state == S_READ);
    rd_addr = (state == S_READ) ? {idx, k[DW-1:0]} : {idx, {DW{1'b0}}};
    wr_en   = (state == S_CHECK) && (cur.op == OP_INSERT) &&
              (!b_used || cmp == cur.key) && (b_fill < FW'(BUCKET_DEPTH));
    wr_addr = {idx, b_fill[DW-1:0]};
  end

  // sequencer: restoring modulo, probe walk, then result or readout
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_take) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid && !res_valid) begin
            cur   <= req;
            size  <= eff;
            rem   <= req.key;
            mstep <= 6'd31;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (!trial[CW+31]) rem <= trial[31:0];
          if (mstep == 6'd0) begin
            state <= S_PROBE;
            steps <= '0;
          end else begin
            mstep <= mstep - 6'd1;
          end
          if (mstep == 6'd0) idx <= (!trial[CW+31]) ? trial[BW-1:0] : rem[BW-1:0];
        end
        S_PROBE: begin
          b_used <= used[idx];
          b_fill <= used[idx] ? fill[idx] : '0;
          state  <= S_WAITRD;
        end
        S_WAITRD: state <= S_CHECK;
        S_CHECK: begin
          if (cur.op == OP_INSERT) begin
            if (!b_used || cmp == cur.key) begin
              last  <= 1'b1;
              out_first <= '0; out_second <= '0; out_third <= '0;
              if (b_fill >= FW'(BUCKET_DEPTH)) status <= ST_BUCKET_FULL;
              else begin
                status    <= ST_INSERTED;
                fill[idx] <= b_fill + FW'(1);
                used[idx] <= 1'b1;
              end
              state <= S_RES;
            end else if (steps + SW'(1) >= size) begin
              status <= ST_TABLE_FULL; last <= 1'b1;
              out_first <= '0; out_second <= '0; out_third <= '0;
              state <= S_RES;
            end else begin
              steps <= steps + SW'(1);
              idx   <= (SW'(idx) + SW'(1) >= size) ? '0 : idx + BW'(1);
              state <= S_PROBE;
            end
          end else begin
            if (!b_used || steps + SW'(1) > size) begin
              status <= ST_NOT_FOUND; last <= 1'b1;
              out_first <= '0; out_second <= '0; out_third <= '0;
              state <= S_RES;
            end else if (b_fill != '0 && cmp == cur.key) begin
              n     <= b_fill;
              k     <= '0;
              state <= S_READ;
            end else if (steps + SW'(1) >= size) begin
              status <= ST_NOT_FOUND; last <= 1'b1;
              out_first <= '0; out_second <= '0; out_third <= '0;
              state <= S_RES;
            end else begin
              steps <= steps + SW'(1);
              idx   <= (SW'(idx) + SW'(1) >= size) ? '0 : idx + BW'(1);
              state <= S_PROBE;
            end
          end
        end
        S_READ:  state <= S_RWAIT;
        S_RWAIT: state <= S_EMIT;
        S_EMIT: begin
          if (!res_valid) begin
            status     <= ST_MATCH;
            out_first  <= rd_f;
            out_second <= rd_s;
            out_third  <= rd_t;
            last       <= (k + FW'(1) == n);
            res_valid  <= 1'b1;
            k          <= k + FW'(1);
            state      <= (k + FW'(1) == n) ? S_IDLE : S_READ;
          end
        end
        S_RES: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/linear_probe_join_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_join_table: hash-join table with linear probing
// Stores triples in fixed-depth buckets keyed by a configured field.
// ----------------------------------------------------------------------------
// One item at a time: the key is reduced modulo the configured table size by a
// 32-step restoring divider, then each probed bucket passes through the states
// S_PROBE, S_WAITRD and S_CHECK on the entry memory read port, and a match
// reads out its stored triples one at a time through S_READ, S_RWAIT and
// S_EMIT, holding in S_EMIT while the previous word waits to be popped.
// A two-entry request queue keeps taking words while the engine is busy. Reset
// clears the table at once through per-bucket valid bits; there is no clearing
// pass.
module linear_probe_join_table import lpjt_pkg::*; #(
  parameter int NUM_BUCKETS  = 256,
  parameter int BUCKET_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        op,
  input  logic [31:0] first_field,
  input  logic [31:0] second_field,
  input  logic [31:0] third_field,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [31:0] out_first,
  output logic [31:0] out_second,
  output logic [31:0] out_third,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [8:0] hash_size;
  logic [1:0] build_sel, stored_sel, probe_sel;
  logic       req_valid, req_take, res_valid;
  req_t       req;

  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_size  <= 9'd256;
      build_sel  <= 2'd0;
      stored_sel <= 2'd0;
      probe_sel  <= 2'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HASH_SIZE:  hash_size  <= cfg_data[8:0];
        CFG_BUILD_KEY:  build_sel  <= cfg_data[1:0];
        CFG_STORED_KEY: stored_sel <= cfg_data[1:0];
        CFG_PROBE_KEY:  probe_sel  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  lpjt_front u_front (
    .clk, .rst, .push, .full, .op, .first_field, .second_field, .third_field,
    .build_sel, .probe_sel, .req_valid, .req, .req_take
  );

  lpjt_back #(.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_back (
    .clk, .rst, .req_valid, .req, .req_take, .hash_size, .build_sel,
    .stored_sel, .res_valid, .res_take(pop), .status, .out_first, .out_second,
    .out_third, .last
  );

  // a shown word holds while not popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(status) && $stable(out_first))
    else $error("result word changed while waiting");
  // status is always a defined code
  a_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status <= ST_NOT_FOUND)
    else $error("bad status code");
  // non-match results carry zero data
  a_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status != ST_MATCH |-> last && out_first == 32'd0)
    else $error("non-match result malformed");

endmodule
